// File: rtl/dpdd_pkg.sv
// shared constants and types for the dual pid differential drive block
`timescale 1ns / 1ps

package dpdd_pkg;

	localparam int WINDOW_DEF      = 16;
	localparam int DERIV_LAG_DEF   = 4;
	localparam int MOTOR_LIMIT_DEF = 32767;

	localparam int DATA_W  = 32;
	localparam int LIM_W   = 31;
	localparam int CFG_W   = 4;
	localparam int DUTY_W  = 16;

	// result queue depth, covers the pipeline so a full rate stream never stalls while out_stall stays low
	localparam int OUT_DEPTH = 8;

	localparam int LOOP_DIST = 0;
	localparam int LOOP_HEAD = 1;

	typedef enum logic [CFG_W-1:0] {
		CFG_ANGLE_KP  = 4'd0,
		CFG_ANGLE_KI  = 4'd1,
		CFG_ANGLE_KD  = 4'd2,
		CFG_ANGLE_LIM = 4'd3,
		CFG_DIST_KP   = 4'd4,
		CFG_DIST_KI   = 4'd5,
		CFG_DIST_KD   = 4'd6,
		CFG_DIST_LIM  = 4'd7
	} cfg_idx_t;

	typedef struct packed {
		logic              right_reverse;
		logic [DUTY_W-1:0] right_duty;
		logic              left_reverse;
		logic [DUTY_W-1:0] left_duty;
	} drive_t;

endpackage

// File: rtl/dual_pid_differential_drive.sv
// top level: dual pid loops with windowed integral driving two motors
//
// channel   direction  handshake             payload
// in        sink       in_valid / in_stall   dist_error, heading_error, dist_enable, heading_enable
// out       source     out_valid / out_stall right_reverse, right_duty, left_reverse, left_duty
// config    sink       wr_en                 wr_index, wr_data
//
// one item per cycle sustained while in_stall stays low; a result passes the stage registers into
// the output queue and can show on out_valid the cycle after it is written.
// the error rings live in one two-read-port memory per loop, read at transfer and written
// back in the next cycle; a write that meets a read of the same entry is forwarded.
// reset clears gains, sums, indexes, ring valid bits and the queue; no clearing pass.
// in_stall rises only when the output queue plus the items in flight reach its depth.
`timescale 1ns / 1ps

module dual_pid_differential_drive #(
	parameter int WINDOW      = dpdd_pkg::WINDOW_DEF,
	parameter int DERIV_LAG   = dpdd_pkg::DERIV_LAG_DEF,
	parameter int MOTOR_LIMIT = dpdd_pkg::MOTOR_LIMIT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               wr_en,
	input  logic [dpdd_pkg::CFG_W-1:0]         wr_index,
	input  logic [dpdd_pkg::DATA_W-1:0]        wr_data,

	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [dpdd_pkg::DATA_W-1:0] dist_error,
	input  logic signed [dpdd_pkg::DATA_W-1:0] heading_error,
	input  logic                               dist_enable,
	input  logic                               heading_enable,

	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               right_reverse,
	output logic [dpdd_pkg::DUTY_W-1:0]        right_duty,
	output logic                               left_reverse,
	output logic [dpdd_pkg::DUTY_W-1:0]        left_duty
);

	localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int LAG_W   = IDX_W + 1;
	localparam int LAG_MOD = DERIV_LAG % WINDOW;
	localparam int Q_PTR_W = $clog2(dpdd_pkg::OUT_DEPTH);
	localparam int Q_CNT_W = $clog2(dpdd_pkg::OUT_DEPTH + 1);

	// gains and limits, index 0 is the distance loop, 1 the heading loop
	logic signed [31:0] kp_q [2];
	logic signed [31:0] ki_q [2];
	logic signed [31:0] kd_q [2];
	logic [dpdd_pkg::LIM_W-1:0] lim_q [2];

	logic               accept;
	logic signed [31:0] err_in [2];
	logic               en_in  [2];

	// stage 1: ring read data is valid
	logic               v_s1;
	logic               en_s1       [2];
	logic signed [31:0] e_s1        [2];
	logic [IDX_W-1:0]   waddr_s1    [2];
	logic [IDX_W-1:0]   laddr_s1    [2];
	logic               coll_old_s1 [2];
	logic               coll_lag_s1 [2];
	logic signed [31:0] fwd_s1      [2];
	logic signed [31:0] old_rd_s1   [2];
	logic signed [31:0] lag_rd_s1   [2];
	logic               old_vld_s1  [2];
	logic               lag_vld_s1  [2];

	// stage 2: clamped sum and derivative
	logic               v_s2;
	logic signed [31:0] e_s2 [2];
	logic signed [31:0] s_s2 [2];
	logic signed [32:0] d_s2 [2];

	// stage 3: products
	logic               v_s3;
	logic signed [63:0] pe_s3 [2];
	logic signed [63:0] ps_s3 [2];
	logic signed [64:0] pd_s3 [2];

	// stage 4: loop outputs
	logic               v_s4;
	logic signed [66:0] lo_s4 [2];

	// stage 5: wheel commands in q32.32
	logic               v_s5;
	logic signed [67:0] right_s5;
	logic signed [67:0] left_s5;

	// output queue
	dpdd_pkg::drive_t   q_mem [dpdd_pkg::OUT_DEPTH];
	logic [Q_PTR_W-1:0] q_wr_ptr_q;
	logic [Q_PTR_W-1:0] q_rd_ptr_q;
	logic [Q_CNT_W-1:0] q_cnt_q;
	logic [Q_CNT_W-1:0] credit_q;
	logic               pop;
	dpdd_pkg::drive_t   q_head;
	dpdd_pkg::drive_t   q_new;

	// truncate toward zero, saturate, split into direction and duty
	function automatic dpdd_pkg::drive_t to_drive(input logic signed [67:0] r,
		input logic signed [67:0] l);
		logic signed [35:0] ip [2];
		logic signed [35:0] lim;
		logic signed [35:0] mag;
		logic               rev [2];
		logic [15:0]        duty [2];
		dpdd_pkg::drive_t   res;
		lim   = 36'(MOTOR_LIMIT);
		ip[0] = $signed(r[67:32]);
		ip[1] = $signed(l[67:32]);
		if (r[67] && (r[31:0] != 32'd0)) ip[0] = ip[0] + 36'sd1;
		if (l[67] && (l[31:0] != 32'd0)) ip[1] = ip[1] + 36'sd1;
		for (int k = 0; k < 2; k++) begin
			if (ip[k] > lim) begin
				ip[k] = lim;
			end else if (ip[k] < -lim) begin
				ip[k] = -lim;
			end
			rev[k]  = ip[k][35];
			mag     = rev[k] ? -ip[k] : ip[k];
			duty[k] = {mag[14:0], 1'b0};
		end
		res.right_reverse = rev[0];
		res.right_duty    = duty[0];
		res.left_reverse  = rev[1];
		res.left_duty     = duty[1];
		return res;
	endfunction

	assign accept    = in_valid && !in_stall;
	assign err_in[0] = dist_error;
	assign err_in[1] = heading_error;
	assign en_in[0]  = dist_enable;
	assign en_in[1]  = heading_enable;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 2; k++) begin
				kp_q[k]  <= '0;
				ki_q[k]  <= '0;
				kd_q[k]  <= '0;
				lim_q[k] <= '0;
			end
		end else if (wr_en) begin
			unique case (wr_index)
				dpdd_pkg::CFG_ANGLE_KP:  kp_q[dpdd_pkg::LOOP_HEAD]  <= $signed(wr_data);
				dpdd_pkg::CFG_ANGLE_KI:  ki_q[dpdd_pkg::LOOP_HEAD]  <= $signed(wr_data);
				dpdd_pkg::CFG_ANGLE_KD:  kd_q[dpdd_pkg::LOOP_HEAD]  <= $signed(wr_data);
				dpdd_pkg::CFG_ANGLE_LIM: lim_q[dpdd_pkg::LOOP_HEAD] <= wr_data[30:0];
				dpdd_pkg::CFG_DIST_KP:   kp_q[dpdd_pkg::LOOP_DIST]  <= $signed(wr_data);
				dpdd_pkg::CFG_DIST_KI:   ki_q[dpdd_pkg::LOOP_DIST]  <= $signed(wr_data);
				dpdd_pkg::CFG_DIST_KD:   kd_q[dpdd_pkg::LOOP_DIST]  <= $signed(wr_data);
				dpdd_pkg::CFG_DIST_LIM:  lim_q[dpdd_pkg::LOOP_DIST] <= wr_data[30:0];
				default: ;
			endcase
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	for (genvar g = 0; g < 2; g++) begin : g_loop
		logic signed [31:0] ring_mem [WINDOW];
		logic [WINDOW-1:0]  ring_vld_q;
		logic [IDX_W-1:0]   idx_q;
		logic signed [31:0] sum_q;
		logic [IDX_W-1:0]   idx_nxt;
		logic [LAG_W-1:0]   lag_sum;
		logic [IDX_W-1:0]   lag_addr;
		logic               we;
		logic signed [31:0] old_val;
		logic signed [31:0] lag_val;
		logic signed [33:0] raw;
		logic signed [33:0] lim34;
		logic signed [31:0] s_cl;

		assign idx_nxt = (idx_q == IDX_W'(WINDOW - 1)) ? '0 : idx_q + 1'b1;
		// entry a lag back from the advanced index, modulo the window
		assign lag_sum  = {1'b0, idx_nxt} + LAG_W'(WINDOW - LAG_MOD);
		assign lag_addr = (lag_sum >= LAG_W'(WINDOW)) ?
			IDX_W'(lag_sum - LAG_W'(WINDOW)) : IDX_W'(lag_sum);
		assign we = v_s1 && en_s1[g];

		always_ff @(posedge clk) begin
			if (we) ring_mem[waddr_s1[g]] <= e_s1[g];
			old_rd_s1[g] <= ring_mem[idx_q];
			lag_rd_s1[g] <= ring_mem[lag_addr];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ring_vld_q    <= '0;
				old_vld_s1[g] <= 1'b0;
				lag_vld_s1[g] <= 1'b0;
			end else begin
				if (we) ring_vld_q[waddr_s1[g]] <= 1'b1;
				old_vld_s1[g] <= ring_vld_q[idx_q];
				lag_vld_s1[g] <= ring_vld_q[lag_addr];
			end
		end

		// stage 1 payload, with forwarding of the write landing at the read edge
		always_ff @(posedge clk) begin
			en_s1[g]       <= en_in[g];
			e_s1[g]        <= err_in[g];
			waddr_s1[g]    <= idx_q;
			laddr_s1[g]    <= lag_addr;
			coll_old_s1[g] <= we && (waddr_s1[g] == idx_q);
			coll_lag_s1[g] <= we && (waddr_s1[g] == lag_addr);
			fwd_s1[g]      <= e_s1[g];
		end

		always_comb begin
			if (coll_old_s1[g]) begin
				old_val = fwd_s1[g];
			end else begin
				old_val = old_vld_s1[g] ? old_rd_s1[g] : '0;
			end
			// own write is the newest value of its entry
			if (laddr_s1[g] == waddr_s1[g]) begin
				lag_val = e_s1[g];
			end else if (coll_lag_s1[g]) begin
				lag_val = fwd_s1[g];
			end else begin
				lag_val = lag_vld_s1[g] ? lag_rd_s1[g] : '0;
			end
			raw   = 34'(sum_q) - 34'(old_val) + 34'(e_s1[g]);
			lim34 = $signed({3'b000, lim_q[g]});
			if (raw > lim34) begin
				s_cl = 32'(lim34);
			end else if (raw < -lim34) begin
				s_cl = 32'(-lim34);
			end else begin
				s_cl = 32'(raw);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				idx_q <= '0;
				sum_q <= '0;
			end else begin
				if (accept && en_in[g]) idx_q <= idx_nxt;
				if (we) sum_q <= s_cl;
			end
		end

		// a disabled loop feeds zeros so its terms vanish
		always_ff @(posedge clk) begin
			e_s2[g] <= en_s1[g] ? e_s1[g] : '0;
			s_s2[g] <= en_s1[g] ? s_cl : '0;
			d_s2[g] <= en_s1[g] ? (33'(e_s1[g]) - 33'(lag_val)) : '0;
		end

		always_ff @(posedge clk) begin
			pe_s3[g] <= 64'(e_s2[g]) * 64'(kp_q[g]);
			ps_s3[g] <= 64'(s_s2[g]) * 64'(ki_q[g]);
			pd_s3[g] <= 65'(d_s2[g]) * 65'(kd_q[g]);
			lo_s4[g] <= 67'(pe_s3[g]) + 67'(ps_s3[g]) + 67'(pd_s3[g]);
		end
	end

	always_ff @(posedge clk) begin
		right_s5 <= 68'(lo_s4[dpdd_pkg::LOOP_DIST]) + 68'(lo_s4[dpdd_pkg::LOOP_HEAD]);
		left_s5  <= 68'(lo_s4[dpdd_pkg::LOOP_DIST]) - 68'(lo_s4[dpdd_pkg::LOOP_HEAD]);
	end

	assign q_new = to_drive(right_s5, left_s5);

	always_ff @(posedge clk) begin
		if (v_s5) q_mem[q_wr_ptr_q] <= q_new;
	end

	assign pop    = out_valid && !out_stall;
	assign q_head = q_mem[q_rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_ptr_q <= '0;
			q_rd_ptr_q <= '0;
			q_cnt_q    <= '0;
			credit_q   <= '0;
		end else begin
			if (v_s5) q_wr_ptr_q <= q_wr_ptr_q + 1'b1;
			if (pop)  q_rd_ptr_q <= q_rd_ptr_q + 1'b1;
			q_cnt_q  <= q_cnt_q + Q_CNT_W'(v_s5) - Q_CNT_W'(pop);
			// items transferred in and not yet transferred out
			credit_q <= credit_q + Q_CNT_W'(accept) - Q_CNT_W'(pop);
		end
	end

	assign in_stall      = (credit_q == Q_CNT_W'(dpdd_pkg::OUT_DEPTH));
	assign out_valid     = (q_cnt_q != '0);
	assign right_reverse = q_head.right_reverse;
	assign right_duty    = q_head.right_duty;
	assign left_reverse  = q_head.left_reverse;
	assign left_duty     = q_head.left_duty;

endmodule

// File: test/dual_pid_differential_drive_checker.sv
// checker for the dual pid drive: predicts each motor command and compares the result transfers
`timescale 1ns / 1ps

module dual_pid_differential_drive_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [dpdd_pkg::CFG_W-1:0]         wr_index,
	input  logic [dpdd_pkg::DATA_W-1:0]        wr_data,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic signed [dpdd_pkg::DATA_W-1:0] dist_error,
	input  logic signed [dpdd_pkg::DATA_W-1:0] heading_error,
	input  logic                               dist_enable,
	input  logic                               heading_enable,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic                               right_reverse,
	input  logic [dpdd_pkg::DUTY_W-1:0]        right_duty,
	input  logic                               left_reverse,
	input  logic [dpdd_pkg::DUTY_W-1:0]        left_duty,
	output int                                 fail_count,
	output int                                 outstanding
);

	import dpdd_pkg::*;

	localparam int WIN   = WINDOW_DEF;
	localparam int LAG   = DERIV_LAG_DEF % WINDOW_DEF;
	localparam int ACC_W = 80;

	// loop state, indexed by LOOP_DIST / LOOP_HEAD
	logic signed [DATA_W-1:0] kp [2];
	logic signed [DATA_W-1:0] ki [2];
	logic signed [DATA_W-1:0] kd [2];
	logic [LIM_W-1:0]         sum_limit [2];
	logic signed [DATA_W-1:0] err_ring [2][WIN];
	logic signed [DATA_W-1:0] err_sum [2];
	int unsigned              ring_pos [2];

	drive_t cmd_queue [$];

	// one loop tick; term is the exact q32.32 sum of the p, i and d terms
	task automatic advance_loop(input int lp, input logic signed [DATA_W-1:0] e,
			output logic signed [ACC_W-1:0] term);
		logic signed [39:0] s;
		logic signed [39:0] d;
		logic signed [39:0] lim;
		int unsigned pos;
		int unsigned lag_pos;
		pos = ring_pos[lp];
		lim = {9'd0, sum_limit[lp]};
		s = err_sum[lp] - err_ring[lp][pos] + e;
		if (s > lim)
			s = lim;
		else if (s < -lim)
			s = -lim;
		err_sum[lp] = s[DATA_W-1:0];
		err_ring[lp][pos] = e;
		pos = (pos + 1) % WIN;
		ring_pos[lp] = pos;
		lag_pos = (pos + WIN - LAG) % WIN;
		d = e - err_ring[lp][lag_pos];
		term = e * kp[lp] + s * ki[lp] + d * kd[lp];
	endtask

	// truncate toward zero, saturate, split into reverse flag and doubled duty
	function automatic logic [DUTY_W:0] motor_cmd(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] whole;
		logic signed [ACC_W-1:0] mag;
		logic rev;
		whole = acc >>> 32;
		if (acc < 0 && acc[31:0] != 0)
			whole = whole + 1;
		if (whole > MOTOR_LIMIT_DEF)
			whole = MOTOR_LIMIT_DEF;
		else if (whole < -MOTOR_LIMIT_DEF)
			whole = -MOTOR_LIMIT_DEF;
		rev = (whole < 0);
		mag = rev ? -whole : whole;
		return {rev, mag[DUTY_W-2:0], 1'b0};
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		drive_t want;
		logic signed [ACC_W-1:0] dist_term;
		logic signed [ACC_W-1:0] head_term;
		logic [DUTY_W:0] rcmd;
		logic [DUTY_W:0] lcmd;
		if (!arst_n) begin
			for (int lp = 0; lp < 2; lp++) begin
				kp[lp] = '0;
				ki[lp] = '0;
				kd[lp] = '0;
				sum_limit[lp] = '0;
				err_sum[lp] = '0;
				ring_pos[lp] = 0;
				for (int k = 0; k < WIN; k++)
					err_ring[lp][k] = '0;
			end
			cmd_queue.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					CFG_ANGLE_KP:  kp[LOOP_HEAD] = wr_data;
					CFG_ANGLE_KI:  ki[LOOP_HEAD] = wr_data;
					CFG_ANGLE_KD:  kd[LOOP_HEAD] = wr_data;
					CFG_ANGLE_LIM: sum_limit[LOOP_HEAD] = wr_data[LIM_W-1:0];
					CFG_DIST_KP:   kp[LOOP_DIST] = wr_data;
					CFG_DIST_KI:   ki[LOOP_DIST] = wr_data;
					CFG_DIST_KD:   kd[LOOP_DIST] = wr_data;
					CFG_DIST_LIM:  sum_limit[LOOP_DIST] = wr_data[LIM_W-1:0];
					default: ;
				endcase
			end
			// compare before pushing so a result can never match its own transfer
			if (out_valid && !out_stall) begin
				if (cmd_queue.size() == 0) begin
					$error("result transfer with no command expected");
					fail_count++;
				end else begin
					want = cmd_queue.pop_front();
					if (right_reverse !== want.right_reverse) begin
						$error("right_reverse: expected %0d, got %0d",
							want.right_reverse, right_reverse);
						fail_count++;
					end
					if (right_duty !== want.right_duty) begin
						$error("right_duty: expected %0d, got %0d", want.right_duty, right_duty);
						fail_count++;
					end
					if (left_reverse !== want.left_reverse) begin
						$error("left_reverse: expected %0d, got %0d",
							want.left_reverse, left_reverse);
						fail_count++;
					end
					if (left_duty !== want.left_duty) begin
						$error("left_duty: expected %0d, got %0d", want.left_duty, left_duty);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				dist_term = '0;
				head_term = '0;
				if (dist_enable)
					advance_loop(LOOP_DIST, dist_error, dist_term);
				if (heading_enable)
					advance_loop(LOOP_HEAD, heading_error, head_term);
				rcmd = motor_cmd(dist_term + head_term);
				lcmd = motor_cmd(dist_term - head_term);
				want.right_reverse = rcmd[DUTY_W];
				want.right_duty = rcmd[DUTY_W-1:0];
				want.left_reverse = lcmd[DUTY_W];
				want.left_duty = lcmd[DUTY_W-1:0];
				cmd_queue.push_back(want);
			end
			outstanding = cmd_queue.size();
		end
	end

endmodule

// File: test/dual_pid_differential_drive_tb.sv
// testbench top for the dual pid drive: clock, reset, register setup, tick stimulus and verdict
`timescale 1ns / 1ps

module dual_pid_differential_drive_tb;

	import dpdd_pkg::*;

	typedef enum {GAIN_MILD, GAIN_WIDE, GAIN_EDGE} gain_style_t;

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [CFG_W-1:0] wr_index;
	logic [DATA_W-1:0] wr_data;
	logic in_valid;
	logic in_stall;
	logic signed [DATA_W-1:0] dist_error;
	logic signed [DATA_W-1:0] heading_error;
	logic dist_enable;
	logic heading_enable;
	logic out_valid;
	logic out_stall;
	logic right_reverse;
	logic [DUTY_W-1:0] right_duty;
	logic left_reverse;
	logic [DUTY_W-1:0] left_duty;
	int fail_count;
	int outstanding;
	bit quiet = 1'b0;

	dual_pid_differential_drive uut (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.dist_error(dist_error), .heading_error(heading_error),
		.dist_enable(dist_enable), .heading_enable(heading_enable),
		.out_valid(out_valid), .out_stall(out_stall),
		.right_reverse(right_reverse), .right_duty(right_duty),
		.left_reverse(left_reverse), .left_duty(left_duty)
	);

	dual_pid_differential_drive_checker drive_check (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.dist_error(dist_error), .heading_error(heading_error),
		.dist_enable(dist_enable), .heading_enable(heading_enable),
		.out_valid(out_valid), .out_stall(out_stall),
		.right_reverse(right_reverse), .right_duty(right_duty),
		.left_reverse(left_reverse), .left_duty(left_duty),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	always #6 clk = ~clk;

	// mostly short gaps, a few long ones, none during a quiet phase
	function automatic int idle_len();
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [DATA_W-1:0] rand_gain(input gain_style_t style);
		int unsigned r;
		r = $urandom_range(0, 4);
		case (style)
			GAIN_MILD: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
			GAIN_WIDE: return $urandom();
			default: begin
				if (r == 0)
					return 32'h8000_0000;
				if (r == 1)
					return 32'h7FFF_FFFF;
				if (r == 2)
					return 32'h0000_0000;
				if (r == 3)
					return 32'h0001_0000;
				return 32'hFFFF_0000;
			end
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] rand_limit(input gain_style_t style);
		int unsigned r;
		r = $urandom_range(0, 2);
		case (style)
			GAIN_MILD: return (r == 0) ? 32'd0 : $urandom_range(0, 32'h0040_0000);
			GAIN_WIDE: return $urandom();
			default: begin
				if (r == 0)
					return 32'h0000_0000;
				if (r == 1)
					return 32'h7FFF_FFFF;
				return 32'hFFFF_FFFF;
			end
		endcase
	endfunction

	// errors mostly within +/-64.0 so commands stay off the rails
	function automatic logic [DATA_W-1:0] rand_err();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
		if (r < 85)
			return $urandom();
		if (r < 93)
			return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
		if (r < 95)
			return 32'h8000_0000;
		if (r < 97)
			return 32'h7FFF_FFFF;
		if (r < 99)
			return 32'h0000_0000;
		return 32'hFFFF_FFFF;
	endfunction

	// entered and left at a falling edge
	task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [DATA_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
	endtask

	task automatic load_gains(input gain_style_t style);
		write_reg(CFG_ANGLE_KP, rand_gain(style));
		write_reg(CFG_ANGLE_KI, rand_gain(style));
		write_reg(CFG_ANGLE_KD, rand_gain(style));
		write_reg(CFG_ANGLE_LIM, rand_limit(style));
		write_reg(CFG_DIST_KP, rand_gain(style));
		write_reg(CFG_DIST_KI, rand_gain(style));
		write_reg(CFG_DIST_KD, rand_gain(style));
		write_reg(CFG_DIST_LIM, rand_limit(style));
		// index past the register file, must be dropped
		write_reg(4'd8 + 4'($urandom_range(0, 7)), $urandom());
		wr_en <= 1'b0;
	endtask

	// entered and left at a falling edge; valid stays high into the next tick when there is no gap
	task automatic send_tick(input logic [DATA_W-1:0] d, input logic [DATA_W-1:0] h,
			input logic de, input logic he);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		dist_error <= d;
		heading_error <= h;
		dist_enable <= de;
		heading_enable <= he;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_random_tick();
		int unsigned r;
		logic de;
		logic he;
		r = $urandom_range(0, 99);
		de = (r < 75) || (r >= 90 && r < 95);
		he = (r < 60) || (r >= 75 && r < 90);
		send_tick(rand_err(), rand_err(), de, he);
	endtask

	// out_stall pattern runs on its own
	initial begin
		int n;
		out_stall <= 1'b0;
		@(negedge clk);
		forever begin
			n = idle_len();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	end

	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		gain_style_t style;
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= '0;
		wr_data <= '0;
		in_valid <= 1'b0;
		dist_error <= '0;
		heading_error <= '0;
		dist_enable <= 1'b0;
		heading_enable <= 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// directed: unit proportional gains, heading sum clamp of 8.0, distance sum held at zero
		write_reg(CFG_ANGLE_KP, 32'h0001_0000);
		write_reg(CFG_ANGLE_KI, 32'h0000_8000);
		write_reg(CFG_ANGLE_KD, 32'h0000_4000);
		write_reg(CFG_ANGLE_LIM, 32'h0008_0000);
		write_reg(CFG_DIST_KP, 32'h0001_0000);
		write_reg(CFG_DIST_KI, 32'h0000_4000);
		write_reg(CFG_DIST_KD, 32'h0002_0000);
		write_reg(CFG_DIST_LIM, 32'h0000_0000);
		wr_en <= 1'b0;
		send_tick(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1);
		send_tick(32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b0);
		send_tick(32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0);
		send_tick(32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1);
		send_tick(32'h0000_0000, 32'h8000_0000, 1'b0, 1'b1);
		send_tick(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1);
		// both loops off: zero command, state untouched
		send_tick(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0);
		// fractional commands that truncate toward zero
		send_tick(32'hFFFF_8000, 32'h0000_0000, 1'b1, 1'b0);
		send_tick(32'h0001_8000, 32'hFFFF_C000, 1'b1, 1'b1);
		send_tick(32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b1);
		send_tick(32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 1'b1);
		for (int k = 0; k < 9; k++)
			send_tick(32'(k) << 16, -(32'(k) << 15), 1'b1, 1'b1);
		in_valid <= 1'b0;

		for (int ph = 0; ph < 8; ph++) begin
			while (outstanding != 0)
				@(negedge clk);
			style = gain_style_t'(ph % 3);
			quiet = (ph == 4);
			load_gains(style);
			for (int i = 0; i < 72; i++)
				send_random_tick();
			in_valid <= 1'b0;
		end

		while (outstanding != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
